// ----- hdl/rectangular_to_spherical_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rectangular to spherical converter
// ----------------------------------------------------------------------------
`ifndef RECTANGULAR_TO_SPHERICAL_ASSERT_SVH
`define RECTANGULAR_TO_SPHERICAL_ASSERT_SVH

// same-cycle implication
`define R2S_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r2s assertion failed");

// next-cycle implication
`define R2S_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r2s assertion failed");

`endif

// ----- hdl/r2s_pkg.sv -----
// ----------------------------------------------------------------------------
// r2s_pkg
// Types, constants and helpers shared by the converter and its cells.
// ----------------------------------------------------------------------------
package r2s_pkg;

  localparam int STAGES = 32;
  localparam int CW     = 60;

  localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam logic [1:0]  DIM_2D             = 2'd2;
  localparam logic [1:0]  DIM_RESET          = 2'd3;

  localparam logic [31:0] ATAN_TURNS [STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [31:0]          ang;
  } cd_t;

  typedef struct packed {
    cd_t         cd;
    logic        ovr;
    logic [31:0] ovr_val;
  } cinit_t;

  typedef struct packed {
    logic        two_d;
    logic        degen;
    logic signed [31:0] z;
    logic        az_ovr;
    logic [31:0] az_ovr_val;
  } side_t;

  typedef struct packed {
    logic [32:0] radius;
    logic [31:0] az;
    logic        two_d;
    logic        degen;
    logic        p_ovr;
    logic [31:0] p_ovr_val;
  } pside_t;

  function automatic cinit_t cordic_init(input logic signed [32:0] y,
                                         input logic signed [32:0] x);
    cinit_t c;
    logic signed [32:0] xa;
    logic signed [32:0] ya;
    c.ovr     = (y == 33'sd0) || (x == 33'sd0);
    c.ovr_val = (y == 33'sd0) ? (x[32] ? HALF_TURN : 32'd0)
                              : (y[32] ? THREE_QUARTER_TURN : QUARTER_TURN);
    if (x[32]) begin
      xa         = -x;
      ya         = -y;
      c.cd.ang   = HALF_TURN;
    end else begin
      xa         = x;
      ya         = y;
      c.cd.ang   = 32'd0;
    end
    c.cd.xs = {{3{xa[32]}}, xa, 24'b0};
    c.cd.ys = {{3{ya[32]}}, ya, 24'b0};
    return c;
  endfunction

endpackage

// ----- hdl/r2s_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// r2s_sqrt_cell
// One result bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module r2s_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step_i,
  input  r2s_pkg::sq_t  d_i,
  output r2s_pkg::sq_t  q_o
);
  import r2s_pkg::*;

  logic [63:0] bit_w;
  logic [63:0] rb;
  sq_t         q_nxt;
  sq_t         q_r;

  always_comb begin
    bit_w = 64'h4000_0000_0000_0000 >> {step_i, 1'b0};
    rb    = d_i.r + bit_w;
    if (d_i.n >= rb) begin
      q_nxt.n = d_i.n - rb;
      q_nxt.r = (d_i.r >> 1) + bit_w;
    end else begin
      q_nxt.n = d_i.n;
      q_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;
endmodule

// ----- hdl/r2s_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// r2s_cordic_cell
// One vectoring micro-rotation of the angle pass, registered.
// ----------------------------------------------------------------------------
module r2s_cordic_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step_i,
  input  r2s_pkg::cd_t  d_i,
  output r2s_pkg::cd_t  q_o
);
  import r2s_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cd_t q_nxt;
  cd_t q_r;

  always_comb begin
    dx = d_i.ys >>> step_i;
    dy = d_i.xs >>> step_i;
    if (!d_i.ys[CW-1]) begin
      q_nxt.xs  = d_i.xs + dx;
      q_nxt.ys  = d_i.ys - dy;
      q_nxt.ang = d_i.ang + ATAN_TURNS[step_i];
    end else begin
      q_nxt.xs  = d_i.xs - dx;
      q_nxt.ys  = d_i.ys + dy;
      q_nxt.ang = d_i.ang - ATAN_TURNS[step_i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;
endmodule

// ----- hdl/rectangular_to_spherical.sv -----
// ----------------------------------------------------------------------------
// rectangular_to_spherical
// Cartesian point to radius, azimuth and polar angle, CORDIC cell chain.
//
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata: x, y, z (Q15.16)
// out      out  out_tvalid/out_tready  out_tdata: radius, azimuth, polar
//                                      out_tuser: degenerate
// cfg      in   cfg_valid/cfg_ready    cfg_data: dimensions
//
// One point per cycle while the output is not stalled; stages: input, squares,
// 32 square-root and azimuth cells, 32 polar cells, output register.
// rst_n clears all valid bits and sets dimensions to 3D.
// A stalled output freezes the whole chain; in_tready follows it.
// ----------------------------------------------------------------------------
module rectangular_to_spherical (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // x_coord, y_coord, z_coord
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // radius, azimuth, polar_angle, zero pad
  output logic         out_tuser,  // degenerate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data    // dimensions
);
  import r2s_pkg::*;
  `include "rectangular_to_spherical_assert.svh"

  logic        en;
  logic [1:0]  dim_r;
  logic        v0_r, v1_r;
  logic signed [31:0] x0_r, y0_r, z0_r, x1_r, y1_r, z1_r;
  logic        td0_r, td1_r, dg1_r;
  logic [31:0] ax, ay, az;
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic        vf_r [STAGES];
  logic        vp_r [STAGES];
  side_t       side_r [STAGES];
  pside_t      ps_r [STAGES];
  sq_t         pl_q [STAGES];
  sq_t         to_q [STAGES];
  cd_t         az_q [STAGES];
  cd_t         po_q [STAGES];
  sq_t         pl_in, to_in;
  cinit_t      az_init, po_init;
  side_t       side_in;
  pside_t      ps_in;
  logic [31:0] p_raw, p_fin;
  logic        out_valid_r;
  logic [32:0] rad_r;
  logic [31:0] azo_r, pol_r;
  logic        dgo_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) dim_r <= DIM_RESET;
    else if (cfg_valid) dim_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
    end
  end

  always_comb begin
    ax = x0_r[31] ? 32'(-x0_r) : 32'(x0_r);
    ay = y0_r[31] ? 32'(-y0_r) : 32'(y0_r);
    az = z0_r[31] ? 32'(-z0_r) : 32'(z0_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= in_tdata[31:0];
      y0_r  <= in_tdata[63:32];
      z0_r  <= (dim_r == DIM_2D) ? 32'sd0 : in_tdata[95:64];
      td0_r <= (dim_r == DIM_2D);
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
      sqz_r <= az * az;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;
      td1_r <= td0_r;
      dg1_r <= (x0_r == 32'sd0) && (y0_r == 32'sd0) && (z0_r == 32'sd0);
    end
  end

  always_comb begin
    pl_in.n = sqx_r + sqy_r;
    pl_in.r = 64'd0;
    to_in.n = sqx_r + sqy_r + sqz_r;
    to_in.r = 64'd0;
    az_init = cordic_init({y1_r[31], y1_r}, {x1_r[31], x1_r});
    side_in.two_d      = td1_r;
    side_in.degen      = dg1_r;
    side_in.z          = z1_r;
    side_in.az_ovr     = az_init.ovr;
    side_in.az_ovr_val = az_init.ovr_val;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_front
    r2s_sqrt_cell u_pl (
      .clk(clk), .en(en), .step_i(5'(i)),
      .d_i((i == 0) ? pl_in : pl_q[(i == 0) ? 0 : i - 1]), .q_o(pl_q[i]));
    r2s_sqrt_cell u_to (
      .clk(clk), .en(en), .step_i(5'(i)),
      .d_i((i == 0) ? to_in : to_q[(i == 0) ? 0 : i - 1]), .q_o(to_q[i]));
    r2s_cordic_cell u_az (
      .clk(clk), .en(en), .step_i(5'(i)),
      .d_i((i == 0) ? az_init.cd : az_q[(i == 0) ? 0 : i - 1]), .q_o(az_q[i]));
    always_ff @(posedge clk) begin
      if (!rst_n) vf_r[i] <= 1'b0;
      else if (en) vf_r[i] <= (i == 0) ? v1_r : vf_r[(i == 0) ? 0 : i - 1];
    end
    always_ff @(posedge clk) begin
      if (en) side_r[i] <= (i == 0) ? side_in : side_r[(i == 0) ? 0 : i - 1];
    end
  end

  always_comb begin
    po_init = cordic_init({1'b0, pl_q[STAGES-1].r[31:0]},
                          {side_r[STAGES-1].z[31], side_r[STAGES-1].z});
    ps_in.radius    = side_r[STAGES-1].degen ? 33'd0 : {1'b0, to_q[STAGES-1].r[31:0]};
    ps_in.az        = side_r[STAGES-1].degen ? 32'd0 :
                      side_r[STAGES-1].az_ovr ? side_r[STAGES-1].az_ovr_val
                                              : az_q[STAGES-1].ang;
    ps_in.two_d     = side_r[STAGES-1].two_d;
    ps_in.degen     = side_r[STAGES-1].degen;
    ps_in.p_ovr     = po_init.ovr;
    ps_in.p_ovr_val = po_init.ovr_val;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_polar
    r2s_cordic_cell u_po (
      .clk(clk), .en(en), .step_i(5'(i)),
      .d_i((i == 0) ? po_init.cd : po_q[(i == 0) ? 0 : i - 1]), .q_o(po_q[i]));
    always_ff @(posedge clk) begin
      if (!rst_n) vp_r[i] <= 1'b0;
      else if (en) vp_r[i] <= (i == 0) ? vf_r[STAGES-1] : vp_r[(i == 0) ? 0 : i - 1];
    end
    always_ff @(posedge clk) begin
      if (en) ps_r[i] <= (i == 0) ? ps_in : ps_r[(i == 0) ? 0 : i - 1];
    end
  end

  always_comb begin
    p_raw = ps_r[STAGES-1].p_ovr ? ps_r[STAGES-1].p_ovr_val : po_q[STAGES-1].ang;
    if (ps_r[STAGES-1].two_d || ps_r[STAGES-1].degen) p_fin = 32'd0;
    else if (p_raw > HALF_TURN) p_fin = (p_raw >= THREE_QUARTER_TURN) ? 32'd0 : HALF_TURN;
    else p_fin = p_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vp_r[STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= ps_r[STAGES-1].radius;
      azo_r <= ps_r[STAGES-1].az;
      pol_r <= p_fin;
      dgo_r <= ps_r[STAGES-1].degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, pol_r, azo_r, rad_r};
  assign out_tuser  = dgo_r;

  `R2S_ASSERT_NOW(a_degen_zero, out_valid_r && dgo_r,
                  rad_r == 33'd0 && azo_r == 32'd0 && pol_r == 32'd0)
  `R2S_ASSERT_NOW(a_polar_range, out_valid_r, pol_r <= HALF_TURN)
  `R2S_ASSERT_NOW(a_stall_blocks, out_valid_r && !out_tready, !in_tready)
  `R2S_ASSERT_NEXT(a_radius_bound, en && vp_r[STAGES-1], rad_r[32] == 1'b0)
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: rectangular_to_spherical testbench
// Streams Q15.16 points through the converter while the sender and receiver
// idle at random. A built-in CORDIC predictor computes radius, azimuth, polar
// angle and the degenerate flag for each beat. Runs in 3D, 2D and the odd
// dimension codes.
// ----------------------------------------------------------------------------
module tb;
  import r2s_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [32:0] radius;
    logic [31:0] azimuth;
    logic [31:0] polar;
    logic        degen;
  } sph_t;

  localparam int LATENCY = 68;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [31:0] ARC_STEP [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_data;

  logic [95:0] point_q[$];
  sph_t        sph_q[$];
  logic [1:0]  dims;
  int          errors;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_cnt;

  rectangular_to_spherical dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] turn_angle(longint ya, longint xa);
    longint xs;
    longint ys;
    longint dx;
    longint dy;
    logic [31:0] ang;
    if (ya == 0) return (xa >= 0) ? 32'd0 : HALF_TURN;
    if (xa == 0) return (ya > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
    xs = xa;
    ys = ya;
    ang = 32'd0;
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      ang = HALF_TURN;
    end
    xs = xs * (64'sd1 <<< 24);
    ys = ys * (64'sd1 <<< 24);
    for (int i = 0; i < 32; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs = xs + dx;
        ys = ys - dy;
        ang = ang + ARC_STEP[i];
      end else begin
        xs = xs - dx;
        ys = ys + dy;
        ang = ang - ARC_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic sph_t to_spherical(logic [95:0] pt, logic [1:0] d);
    sph_t s;
    longint x;
    longint y;
    longint z;
    longint unsigned planar;
    logic two_d;
    logic [31:0] p;
    x = longint'(signed'(pt[31:0]));
    y = longint'(signed'(pt[63:32]));
    z = longint'(signed'(pt[95:64]));
    two_d = (d == DIM_2D);
    if (two_d) z = 0;
    planar = longint'(x * x) + longint'(y * y);
    s = '0;
    s.radius = 33'(int_sqrt(planar + longint'(z * z)));
    if (x == 0 && y == 0 && z == 0) begin
      s.degen = 1'b1;
      s.radius = '0;
    end else begin
      s.azimuth = turn_angle(y, x);
      if (!two_d) begin
        p = turn_angle(longint'(int_sqrt(planar)), z);
        if (p > HALF_TURN) p = (p >= THREE_QUARTER_TURN) ? 32'd0 : HALF_TURN;
        s.polar = p;
      end
    end
    return s;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      4: return 32'(int'($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [95:0] rand_point();
    logic [31:0] c [3];
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        foreach (c[i]) c[i] = $urandom;
      end
      4, 5: begin
        foreach (c[i]) c[i] = rand_coord();
      end
      6: begin
        foreach (c[i]) c[i] = $urandom;
        c[$urandom_range(0, 2)] = 32'd0;
      end
      7: begin
        k = $urandom_range(0, 2);
        foreach (c[i]) c[i] = (i == k) ? rand_coord() : 32'd0;
      end
      default: begin
        foreach (c[i]) c[i] = 32'(int'($urandom_range(0, 64)) - 32);
      end
    endcase
    return {c[2], c[1], c[0]};
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (point_q.size() != 0 || in_tvalid || sph_q.size() != 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_dims(logic [1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    dims = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_directed();
    logic [31:0] mn;
    logic [31:0] mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    point_q.push_back({32'd0, 32'd0, 32'd0});
    point_q.push_back({32'd0, 32'd0, 32'h0001_0000});
    point_q.push_back({32'd0, 32'd0, 32'hffff_0000});
    point_q.push_back({32'd0, 32'h0001_0000, 32'd0});
    point_q.push_back({32'd0, 32'hffff_0000, 32'd0});
    point_q.push_back({32'h0001_0000, 32'd0, 32'd0});
    point_q.push_back({32'hffff_0000, 32'd0, 32'd0});
    point_q.push_back({mx, mx, mx});
    point_q.push_back({mn, mn, mn});
    point_q.push_back({mx, mn, mx});
    point_q.push_back({mn, mx, mn});
    point_q.push_back({32'd0, 32'd0, mn});
    point_q.push_back({mn, 32'd0, 32'd0});
    point_q.push_back({32'd0, mn, 32'd0});
    point_q.push_back({32'd5, 32'd0, 32'd0});
    point_q.push_back({32'd1, 32'd1, 32'd1});
    point_q.push_back({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    point_q.push_back({32'd1, 32'd0, 32'd0});
    point_q.push_back({32'h1234_5678, 32'd0, 32'd0});
    point_q.push_back({32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff});
    point_q.push_back({32'h8000_0000, 32'h0000_0001, 32'h0000_0001});
  endtask

  task automatic run_phase(int n);
    load_directed();
    for (int i = 0; i < n; i++) point_q.push_back(rand_point());
    drain();
  endtask

  always @(posedge clk) begin
    logic next_valid;
    logic [95:0] next_data;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      next_valid = in_tvalid;
      next_data  = in_tdata;
      if (in_tvalid && in_tready) begin
        sph_q.push_back(to_spherical(in_tdata, dims));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (point_q.size() != 0) begin
          next_data  = point_q.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_tvalid <= next_valid;
      in_tdata  <= next_data;
    end
  end

  always @(posedge clk) begin
    sph_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode <= 0;
      stall_cnt  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sph_q.size() == 0) begin
          report("unexpected beat", 64'(out_tdata[96:0]), 64'd0);
        end else begin
          want = sph_q.pop_front();
          if (out_tdata[32:0] !== want.radius)
            report("radius", 64'(out_tdata[32:0]), 64'(want.radius));
          if (out_tdata[64:33] !== want.azimuth)
            report("azimuth", 64'(out_tdata[64:33]), 64'(want.azimuth));
          if (out_tdata[96:65] !== want.polar)
            report("polar_angle", 64'(out_tdata[96:65]), 64'(want.polar));
          if (out_tuser !== want.degen)
            report("degenerate", 64'(out_tuser), 64'(want.degen));
        end
      end
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_cnt  <= $urandom_range(50, 400);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = DIM_RESET;
    dims        = DIM_RESET;
    errors      = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_phase(600);
    write_dims(DIM_2D);
    run_phase(400);
    write_dims(2'd0);
    run_phase(200);
    write_dims(2'd1);
    run_phase(200);
    write_dims(2'd3);
    run_phase(200);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/r2s_pkg.sv
hdl/r2s_sqrt_cell.sv
hdl/r2s_cordic_cell.sv
hdl/rectangular_to_spherical.sv
verif/tb.sv
